// ===== src/bspw_pkg.sv =====
package bspw_pkg;

    localparam int DATA_W    = 8;
    localparam int CHAN_W    = 6;
    localparam int STRETCH_W = 5;
    localparam int LFSR_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;
    localparam int SRC_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STRETCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIX_CH  = 2'd2;

    localparam logic [STRETCH_W-1:0] STRETCH_RST = 5'd30;
    localparam logic [CHAN_W-1:0]    CHAN_RST    = 6'd37;
    localparam logic [CHAN_W-1:0]    ADV_CH_BASE = 6'd37;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take a new input beat
        logic skip;   // clock whitener 8 times, header byte
        logic emit;   // produce one output byte into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_byte;  // byte about to be emitted closes the run
    } status_t;

endpackage

// ===== src/bspw_dp.sv =====
module bspw_dp
    import bspw_pkg::*;
#(
    parameter int MAX_STRETCH = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [DATA_W-1:0]    in_data,
    input  logic                 in_sop,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [DATA_W-1:0]    out_byte,
    output logic [CHAN_W-1:0]    out_chan,
    output logic                 out_last
);

    logic [STRETCH_W-1:0] stretch_reg;
    logic                 hop_reg;
    logic [CHAN_W-1:0]    fixed_reg;

    logic [LFSR_W-1:0]    lfsr_reg, lfsr_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    logic [DATA_W-1:0]    data_reg;
    logic [SRC_W-1:0]     src_reg, src_next;
    logic [STRETCH_W-1:0] rep_reg, rep_next;
    logic [STRETCH_W-1:0] bcnt_reg;
    logic [DATA_W-1:0]    obyte_reg;
    logic [CHAN_W-1:0]    ochan_reg;
    logic                 olast_reg;

    logic [STRETCH_W-1:0] s_eff;
    logic [LFSR_W-1:0]    lfsr_adv;
    logic [DATA_W-1:0]    byte_w;
    logic [SRC_W-1:0]     src_adv;
    logic [STRETCH_W-1:0] rep_adv;

    // 37 + (((ch + 1) mod 37) mod 3), mod 3 by base-4 digit sums
    function automatic logic [CHAN_W-1:0] hop_next(input logic [CHAN_W-1:0] ch);
        logic [CHAN_W:0]   v;
        logic [CHAN_W-1:0] m;
        logic [3:0]        d;
        logic [2:0]        e;
        logic [1:0]        r;
        v = {1'b0, ch} + 7'd1;
        m = (v >= 7'd37) ? CHAN_W'(v - 7'd37) : CHAN_W'(v);
        d = 4'(m[1:0]) + 4'(m[3:2]) + 4'(m[5:4]);
        e = 3'(d[1:0]) + 3'(d[3:2]);
        r = (e >= 3'd3) ? 2'(e - 3'd3) : 2'(e);
        return ADV_CH_BASE + CHAN_W'(r);
    endfunction

    always_comb begin
        if (stretch_reg == '0) begin
            s_eff = STRETCH_W'(1);
        end else if (int'(stretch_reg) > MAX_STRETCH) begin
            s_eff = STRETCH_W'(MAX_STRETCH);
        end else begin
            s_eff = stretch_reg;
        end
    end

    // eight whitener steps; data bit walks MSB first, each repeated s_eff times
    always_comb begin
        logic [LFSR_W-1:0]    lf;
        logic [SRC_W-1:0]     src;
        logic [STRETCH_W-1:0] rep;
        logic                 fb;
        lf     = lfsr_reg;
        src    = src_reg;
        rep    = rep_reg;
        byte_w = '0;
        for (int i = 0; i < DATA_W; i++) begin
            fb        = lf[0];
            byte_w[i] = data_reg[src] ^ fb;
            lf        = {fb, lf[LFSR_W-1:1]};
            lf[2]     = lf[2] ^ fb;
            if (rep + STRETCH_W'(1) == s_eff) begin
                rep = '0;
                src = src - SRC_W'(1);
            end else begin
                rep = rep + STRETCH_W'(1);
            end
        end
        lfsr_adv = lf;
        src_adv  = src;
        rep_adv  = rep;
    end

    assign status.last_byte = (bcnt_reg + STRETCH_W'(1) == s_eff);

    always_comb begin
        chan_next = chan_reg;
        lfsr_next = lfsr_reg;
        src_next  = src_reg;
        rep_next  = rep_reg;
        if (cmd.load) begin
            src_next = SRC_W'(DATA_W - 1);
            rep_next = '0;
            if (in_sop) begin
                chan_next = hop_reg ? hop_next(chan_reg) : fixed_reg;
                lfsr_next = {1'b1, chan_next};
            end
        end else if (cmd.skip) begin
            lfsr_next = lfsr_adv;
        end else if (cmd.emit) begin
            lfsr_next = lfsr_adv;
            src_next  = src_adv;
            rep_next  = rep_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stretch_reg <= STRETCH_RST;
            hop_reg     <= 1'b1;
            fixed_reg   <= CHAN_RST;
            chan_reg    <= CHAN_RST;
            lfsr_reg    <= {1'b1, CHAN_RST};
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_STRETCH: stretch_reg <= cfg_wdata[STRETCH_W-1:0];
                    REG_HOP_EN:  hop_reg     <= cfg_wdata[0];
                    REG_FIX_CH:  fixed_reg   <= cfg_wdata[CHAN_W-1:0];
                    default: ;
                endcase
            end
            chan_reg <= chan_next;
            lfsr_reg <= lfsr_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        rep_reg <= rep_next;
        if (cmd.load) begin
            data_reg <= in_data;
            bcnt_reg <= '0;
        end else if (cmd.emit) begin
            bcnt_reg  <= bcnt_reg + STRETCH_W'(1);
            obyte_reg <= byte_w;
            ochan_reg <= chan_reg;
            olast_reg <= status.last_byte;
        end
    end

    assign out_byte = obyte_reg;
    assign out_chan = ochan_reg;
    assign out_last = olast_reg;

    a_seed_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && in_sop) |=> lfsr_reg[LFSR_W-1])
        else $error("whitener seed lacks top bit");

    a_hop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && in_sop && hop_reg) |=>
        (chan_reg == 6'd37 || chan_reg == 6'd38 || chan_reg == 6'd39))
        else $error("hopped channel outside advertising set");

endmodule

// ===== src/bspw_ctrl.sv =====
module bspw_ctrl
    import bspw_pkg::*;
#(
    parameter int HEADER_SKIP_BYTES = 9
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int HW = (HEADER_SKIP_BYTES > 1) ? $clog2(HEADER_SKIP_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [HW-1:0]   hdr_reg, hdr_next;
    logic            mvalid_reg, mvalid_next;
    logic            out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        hdr_next    = hdr_reg;
        mvalid_next = m_tready ? 1'b0 : mvalid_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    hdr_next = '0;
                    if (s_tuser && HEADER_SKIP_BYTES > 0) begin
                        state_next = ST_SKIP;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SKIP: begin
                cmd.skip = 1'b1;
                hdr_next = hdr_reg + HW'(1);
                if (hdr_reg == HW'(HEADER_SKIP_BYTES - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit    = 1'b1;
                    mvalid_next = 1'b1;
                    if (status.last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            hdr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            hdr_reg    <= hdr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (state_reg == ST_EMIT) && out_free)
        else $error("emit into an occupied output register");

    a_run_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.last_byte) |=> (state_reg == ST_IDLE) && mvalid_reg)
        else $error("run did not close after last byte");

endmodule

// ===== src/ble_stretched_payload_whitener.sv =====
// Each input beat yields stretch_factor output beats, one per cycle when m_tready is high.
// Per item: accept, then stretch_factor emits; a start-of-packet beat first clocks the
// whitener past HEADER_SKIP_BYTES header bytes, 8 steps per cycle.
// First output beat: accept, skip state on start of packet, emit state, output register.
// The 8-step whitener sets the rate: one byte per cycle unless stalled, up to 30 per item.
// Synchronous active-low reset: idle, registers to 30/1/37, channel 37, whitener 0x65.
module ble_stretched_payload_whitener
    import bspw_pkg::*;
#(
    parameter int HEADER_SKIP_BYTES = 9,
    parameter int MAX_STRETCH       = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // start_of_packet
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] out_byte, [13:8] channel_used, zero pad
    output logic                 m_tlast    // last_of_run
);

    cmd_t              cmd;
    status_t           status;
    logic [DATA_W-1:0] out_byte;
    logic [CHAN_W-1:0] out_chan;

    bspw_ctrl #(
        .HEADER_SKIP_BYTES(HEADER_SKIP_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bspw_dp #(
        .MAX_STRETCH(MAX_STRETCH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_sop    (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (out_byte),
        .out_chan  (out_chan),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_chan, out_byte};

endmodule
